/* rtl/mrrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request checker package
// Shared constants, status codes, the per-byte CRC-16 step and the
// structs that pass between the top level and the CRC tracker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] BROADCAST_ADDR   = 8'h00;
    localparam logic [7:0] OWN_ADDR_RESET   = 8'h01;
    localparam logic [7:0] FUNC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;

    localparam int MIN_FRAME_BYTES = 5;
    localparam int HEADER_CRC_BYTES = 4;
    localparam logic [7:0] PAYLOAD_BYTES = 8'd4;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_CRC_ERR   = 3'd2,
        STATUS_BAD_ADDR  = 3'd3,
        STATUS_BAD_FUNC  = 3'd4,
        STATUS_BAD_LEN   = 3'd5
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       crc_en;
    } crc_step_t;

    typedef struct packed {
        logic [15:0] calc;
        logic [15:0] received;
    } crc_view_t;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

/* rtl/mrrc_crc_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC tracker
// Two-byte delay line ahead of the CRC-16 accumulator, so the running CRC
// leaves out the trailing two bytes, which form the received CRC.
// ----------------------------------------------------------------------------
module mrrc_crc_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrrc_pkg::crc_step_t  step,
    output mrrc_pkg::crc_view_t  view
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  dly0_reg, dly0_next;
    logic [7:0]  dly1_reg, dly1_next;
    logic [15:0] crc_upd;

    always_comb
    begin
        // the older delayed byte leaves the line into the CRC
        crc_upd = step.crc_en ? mrrc_pkg::crc16_byte(crc_reg, dly0_reg) : crc_reg;
        view.calc     = crc_upd;
        view.received = {step.data, dly1_reg};

        crc_next  = crc_reg;
        dly0_next = dly0_reg;
        dly1_next = dly1_reg;
        if (step.valid)
        begin
            if (step.last)
            begin
                crc_next  = mrrc_pkg::CRC_INIT;
                dly0_next = 8'h00;
                dly1_next = 8'h00;
            end
            else
            begin
                crc_next  = crc_upd;
                dly0_next = dly1_reg;
                dly1_next = step.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= mrrc_pkg::CRC_INIT;
            dly0_reg <= 8'h00;
            dly1_reg <= 8'h00;
        end
        else
        begin
            crc_reg  <= crc_next;
            dly0_reg <= dly0_next;
            dly1_reg <= dly1_next;
        end
    end

endmodule

/* rtl/modbus_rtu_request_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request checker core
// Checks one Modbus RTU request per frame and reports status and fields.
// ----------------------------------------------------------------------------
// Usage:
//   Frame channel: frame_valid/frame_stall carry frame_byte and last_byte,
//   one byte per transaction in wire order; last_byte marks the final byte.
//   Result channel: result_valid/result_stall carry one transaction per
//   frame, issued for the final byte: status and captured fields.
//   Config channel: cfg_valid/cfg_ready write own_address from cfg_data;
//   cfg_ready is always high. Write only while no frame is in progress.
// Timing:
//   A byte is registered in the input register, then the CRC step, field
//   capture and checks run combinationally into the result register,
//   which holds status and fields for the final byte until it is taken.
//   One byte per cycle is sustained while no stalled result holds the
//   input; the eight-bit CRC update sets the cycle path.
// Reset: frame state clears, CRC returns to 0xFFFF, own_address to 1.
// Stall: while a result waits under result_stall, the input register holds
//   one more byte and frame_stall rises only if that register is full.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [7:0]  slave_address,
    output logic [7:0]  function_code,
    output logic [7:0]  payload_length,
    output logic        is_broadcast,
    output logic [15:0] first_word,
    output logic [15:0] second_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int CW = mrrc_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(mrrc_pkg::MAX_FRAME_BYTES);
    localparam logic [CW-1:0] CNT_MIN = CW'(mrrc_pkg::MIN_FRAME_BYTES);
    localparam logic [CW-1:0] CNT_HDR = CW'(mrrc_pkg::HEADER_CRC_BYTES);

    // configuration
    logic [7:0] own_addr_reg;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       hold;
    logic       advance;

    // per-frame state
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    func_reg, func_next;
    logic [31:0]   payload_reg, payload_next;

    // result register
    logic          res_vld_reg, res_vld_next;
    logic [2:0]    status_reg;
    logic [7:0]    addr_out_reg, func_out_reg, plen_reg;
    logic          bcast_reg;
    logic [31:0]   words_reg;

    mrrc_pkg::crc_step_t crc_step;
    mrrc_pkg::crc_view_t crc_view;
    mrrc_pkg::status_t   status_next;
    logic [7:0]          plen_next;

    assign hold        = res_vld_reg && result_stall;
    assign advance     = in_vld_reg && !hold;
    assign frame_stall = in_vld_reg && hold;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            own_addr_reg <= mrrc_pkg::OWN_ADDR_RESET;
        else if (cfg_valid && cfg_ready)
            own_addr_reg <= cfg_data;
    end

    // load the input register whenever it is empty or draining
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!frame_stall)
            in_vld_reg <= frame_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!frame_stall && frame_valid)
        begin
            in_byte_reg <= frame_byte;
            in_last_reg <= last_byte;
        end
    end

    assign crc_step.valid  = advance;
    assign crc_step.data   = in_byte_reg;
    assign crc_step.last   = in_last_reg;
    assign crc_step.crc_en = (count_reg >= CW'(2));

    mrrc_crc_tracker u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (crc_step),
        .view  (crc_view)
    );

    // capture fields and evaluate the checks
    always_comb
    begin
        addr_next    = addr_reg;
        func_next    = func_reg;
        payload_next = payload_reg;
        priority case (1'b1)
            (count_reg == CW'(0)): addr_next = in_byte_reg;
            (count_reg == CW'(1)): func_next = in_byte_reg;
            (count_reg == CW'(2)): payload_next[31:24] = in_byte_reg;
            (count_reg == CW'(3)): payload_next[23:16] = in_byte_reg;
            (count_reg == CW'(4)): payload_next[15:8]  = in_byte_reg;
            (count_reg == CW'(5)): payload_next[7:0]   = in_byte_reg;
            default: ;
        endcase

        count_next = (count_reg < CNT_MAX) ? count_reg + CW'(1) : count_reg;
        plen_next  = (count_next >= CNT_HDR) ? 8'(count_next - CNT_HDR) : 8'h00;

        if (count_next < CNT_MIN)
            status_next = mrrc_pkg::STATUS_SHORT;
        else if (crc_view.calc != crc_view.received)
            status_next = mrrc_pkg::STATUS_CRC_ERR;
        else if (addr_next != own_addr_reg && addr_next != mrrc_pkg::BROADCAST_ADDR)
            status_next = mrrc_pkg::STATUS_BAD_ADDR;
        else if (func_next != mrrc_pkg::FUNC_READ_HOLD
                 && func_next != mrrc_pkg::FUNC_WRITE_SINGLE)
            status_next = mrrc_pkg::STATUS_BAD_FUNC;
        else if (plen_next != mrrc_pkg::PAYLOAD_BYTES)
            status_next = mrrc_pkg::STATUS_BAD_LEN;
        else
            status_next = mrrc_pkg::STATUS_OK;

        if (advance && in_last_reg)
            res_vld_next = 1'b1;
        else if (!result_stall)
            res_vld_next = 1'b0;
        else
            res_vld_next = res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            addr_reg    <= 8'h00;
            func_reg    <= 8'h00;
            payload_reg <= 32'h0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
            if (advance)
            begin
                // drop per-frame state at the end of each frame
                if (in_last_reg)
                begin
                    count_reg   <= '0;
                    addr_reg    <= 8'h00;
                    func_reg    <= 8'h00;
                    payload_reg <= 32'h0;
                end
                else
                begin
                    count_reg   <= count_next;
                    addr_reg    <= addr_next;
                    func_reg    <= func_next;
                    payload_reg <= payload_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            status_reg   <= 3'(status_next);
            addr_out_reg <= addr_next;
            func_out_reg <= func_next;
            plen_reg     <= plen_next;
            bcast_reg    <= (addr_next == mrrc_pkg::BROADCAST_ADDR);
            words_reg    <= payload_next;
        end
    end

    assign result_valid   = res_vld_reg;
    assign status         = status_reg;
    assign slave_address  = addr_out_reg;
    assign function_code  = func_out_reg;
    assign payload_length = plen_reg;
    assign is_broadcast   = bcast_reg;
    assign first_word     = words_reg[31:16];
    assign second_word    = words_reg[15:0];

    // input side backs up only behind a stalled result
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> (result_valid && result_stall))
        else $error("frame_stall without a stalled result");

    a_ok_len : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == 3'(mrrc_pkg::STATUS_OK))
            |-> (payload_length == mrrc_pkg::PAYLOAD_BYTES))
        else $error("ok status with wrong payload length");

    a_count_sat : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("byte count past saturation");

endmodule

/* test/modbus_rtu_request_checker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request checker core testbench
// Feeds request frames byte by byte: a few fixed frames first, then random
// frames (valid requests, corrupted CRCs, short and over-long frames, noise)
// under four own_address settings. A scoreboard predicts each frame's status
// and fields and compares them with every result transaction taken.
// ----------------------------------------------------------------------------
module modbus_rtu_request_checker_core_tb;

    localparam int RANDOM_BYTES     = 500;
    localparam int IDLE_LIMIT       = 3000;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        mrrc_pkg::status_t status;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [7:0]  payload_length;
        logic        is_broadcast;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } request_report_t;

    class request_check_board;
        request_report_t awaited_results[$];
        int              failures;
        logic [7:0]      own_addr;
        logic [15:0]     crc_acc;
        int              byte_total;
        logic [7:0]      older_byte;
        logic [7:0]      newer_byte;
        logic [7:0]      cap_addr;
        logic [7:0]      cap_func;
        logic [31:0]     cap_payload;

        function new();
            failures = 0;
            own_addr = mrrc_pkg::OWN_ADDR_RESET;
            clear_frame();
        endfunction

        // Bit-serial form of the reflected CRC-16 update
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
            logic [15:0] acc;
            acc = crc;
            for (int i = 0; i < 8; i++)
            begin
                if (acc[0] ^ data[i])
                    acc = (acc >> 1) ^ mrrc_pkg::CRC_POLY;
                else
                    acc = acc >> 1;
            end
            return acc;
        endfunction

        function void clear_frame();
            crc_acc     = mrrc_pkg::CRC_INIT;
            byte_total  = 0;
            older_byte  = 8'h00;
            newer_byte  = 8'h00;
            cap_addr    = 8'h00;
            cap_func    = 8'h00;
            cap_payload = 32'h0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            request_report_t exp;
            logic [15:0]     received;
            logic [7:0]      plen;
            // the older delayed byte leaves the line into the CRC
            if (byte_total >= 2)
                crc_acc = crc_step(crc_acc, older_byte);
            older_byte = newer_byte;
            newer_byte = b;
            if (byte_total == 0)
                cap_addr = b;
            else if (byte_total == 1)
                cap_func = b;
            else if (byte_total <= 5)
                cap_payload |= {24'h0, b} << (8 * (5 - byte_total));
            if (byte_total < mrrc_pkg::MAX_FRAME_BYTES)
                byte_total++;
            if (!last)
                return;
            received = {newer_byte, older_byte};
            plen = (byte_total >= mrrc_pkg::HEADER_CRC_BYTES)
                   ? 8'(byte_total - mrrc_pkg::HEADER_CRC_BYTES) : 8'd0;
            if (byte_total < mrrc_pkg::MIN_FRAME_BYTES)
                exp.status = mrrc_pkg::STATUS_SHORT;
            else if (crc_acc != received)
                exp.status = mrrc_pkg::STATUS_CRC_ERR;
            else if (cap_addr != own_addr && cap_addr != mrrc_pkg::BROADCAST_ADDR)
                exp.status = mrrc_pkg::STATUS_BAD_ADDR;
            else if (cap_func != mrrc_pkg::FUNC_READ_HOLD
                     && cap_func != mrrc_pkg::FUNC_WRITE_SINGLE)
                exp.status = mrrc_pkg::STATUS_BAD_FUNC;
            else if (plen != mrrc_pkg::PAYLOAD_BYTES)
                exp.status = mrrc_pkg::STATUS_BAD_LEN;
            else
                exp.status = mrrc_pkg::STATUS_OK;
            exp.slave_address  = cap_addr;
            exp.function_code  = cap_func;
            exp.payload_length = plen;
            exp.is_broadcast   = (cap_addr == mrrc_pkg::BROADCAST_ADDR);
            exp.first_word     = cap_payload[31:16];
            exp.second_word    = cap_payload[15:0];
            awaited_results.push_back(exp);
            clear_frame();
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual)
            begin
                failures++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, expected, actual);
            end
        endfunction

        function void check_result(request_report_t got);
            request_report_t exp;
            if (awaited_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with nothing expected, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            exp = awaited_results.pop_front();
            compare_field("status", int'(exp.status), int'(got.status));
            compare_field("slave_address", int'(exp.slave_address),
                          int'(got.slave_address));
            compare_field("function_code", int'(exp.function_code),
                          int'(got.function_code));
            compare_field("payload_length", int'(exp.payload_length),
                          int'(got.payload_length));
            compare_field("is_broadcast", int'(exp.is_broadcast), int'(got.is_broadcast));
            compare_field("first_word", int'(exp.first_word), int'(got.first_word));
            compare_field("second_word", int'(exp.second_word), int'(got.second_word));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        frame_valid;
    logic        frame_stall;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  status;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [7:0]  payload_length;
    logic        is_broadcast;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    request_check_board board;
    logic [7:0]         frame_q[$];
    int                 bytes_sent = 0;
    bit                 idle_on = 1'b1;
    bit                 long_hold_req = 1'b0;
    int                 idle_cycles = 0;

    modbus_rtu_request_checker_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .slave_address  (slave_address),
        .function_code  (function_code),
        .payload_length (payload_length),
        .is_broadcast   (is_broadcast),
        .first_word     (first_word),
        .second_word    (second_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            frame_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte  <= b;
        last_byte   <= last;
        do
            @(posedge clk);
        while (frame_stall);
        board.note_byte(b, last);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        bytes_sent += frame_q.size();
    endtask

    function automatic void append_crc();
        logic [15:0] crc;
        crc = mrrc_pkg::CRC_INIT;
        foreach (frame_q[i])
            crc = request_check_board::crc_step(crc, frame_q[i]);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endfunction

    // Hold the frame channel until every result is back, then let the pipe settle
    task automatic wait_for_results();
        frame_valid <= 1'b0;
        while (board.awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_own_address(input logic [7:0] addr);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.own_addr = addr;
    endtask

    // Over-long request with a good CRC: count saturates, length check fails
    task automatic long_frame();
        int n;
        n = $urandom_range(257, 264);
        frame_q.delete();
        frame_q.push_back(board.own_addr);
        frame_q.push_back(mrrc_pkg::FUNC_READ_HOLD);
        repeat (n - 4) frame_q.push_back(8'($urandom_range(0, 255)));
        append_crc();
        send_frame();
    endtask

    task automatic random_frame();
        int kind;
        int sel;
        int plen;
        int pos;
        frame_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 20)
        begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                frame_q.push_back(board.own_addr);
            else if (sel < 6)
                frame_q.push_back(mrrc_pkg::BROADCAST_ADDR);
            else
                frame_q.push_back(8'($urandom_range(0, 255)));
            sel = $urandom_range(0, 9);
            if (sel < 4)
                frame_q.push_back(mrrc_pkg::FUNC_READ_HOLD);
            else if (sel < 8)
                frame_q.push_back(mrrc_pkg::FUNC_WRITE_SINGLE);
            else
                frame_q.push_back(8'($urandom_range(0, 255)));
            plen = ($urandom_range(0, 3) != 0) ? int'(mrrc_pkg::PAYLOAD_BYTES)
                                               : int'($urandom_range(0, 9));
            repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
            append_crc();
            // flip one bit somewhere to break the CRC
            if (kind < 35)
            begin
                pos = $urandom_range(0, frame_q.size() - 1);
                frame_q[pos] ^= 8'h01 << $urandom_range(0, 7);
            end
        end
        send_frame();
    endtask

    initial
    begin
        logic [7:0] phase_addr[4];
        int         phase_end;
        board = new();
        rst_n       <= 1'b0;
        frame_valid <= 1'b0;
        frame_byte  <= 8'h00;
        last_byte   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 8'h00;
        phase_addr = '{8'hFF, 8'h00, 8'($urandom_range(2, 254)), mrrc_pkg::OWN_ADDR_RESET};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte frame, good requests at the reset address and broadcast, a short frame, a bad length
        frame_q = '{8'hFF};
        send_frame();
        frame_q = '{8'h01, mrrc_pkg::FUNC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01};
        append_crc();
        send_frame();
        frame_q = '{mrrc_pkg::BROADCAST_ADDR, mrrc_pkg::FUNC_WRITE_SINGLE,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF};
        append_crc();
        send_frame();
        frame_q = '{8'h00, 8'h00, 8'h00};
        send_frame();
        frame_q = '{8'h01, mrrc_pkg::FUNC_READ_HOLD, 8'h7F};
        append_crc();
        send_frame();
        wait_for_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_own_address(phase_addr[phase]);
            if (phase == 3)
                idle_on = 1'b0;
            if (phase == 1)
                long_hold_req = 1'b1;
            if (phase == 2)
                long_frame();
            phase_end = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < phase_end)
                random_frame();
            wait_for_results();
        end

        if (board.failures == 0 && board.awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: take transactions and stall in bursts, plus one long hold
    initial
    begin
        request_report_t got;
        int              stall_left;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                got.status         = mrrc_pkg::status_t'(status);
                got.slave_address  = slave_address;
                got.function_code  = function_code;
                got.payload_length = payload_length;
                got.is_broadcast   = is_broadcast;
                got.first_word     = first_word;
                got.second_word    = second_word;
                board.check_result(got);
            end
            if (stall_left > 0)
                stall_left--;
            else if (long_hold_req)
            begin
                stall_left    = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            result_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
